/* sv/tclmr_pkg.sv */
// shared types and constants for the two-color led matrix refresher
package tclmr_pkg;

   localparam int MAX_PANELS    = 4;
   localparam int PANEL_ROWS    = 16;
   localparam int PANEL_COLUMNS = 32;

   localparam int WORD_COUNT = PANEL_ROWS * MAX_PANELS;
   localparam int ADDR_W     = $clog2(WORD_COUNT);
   localparam int ROW_W      = $clog2(PANEL_ROWS);
   localparam int BIT_W      = $clog2(PANEL_COLUMNS);
   localparam int WIDTH_W    = $clog2(MAX_PANELS * PANEL_COLUMNS + 1);

   localparam int FUNC_W   = 2;
   localparam int X_W      = 10;
   localparam int Y_W      = 5;
   localparam int COLOR_W  = 2;
   localparam int PANEL_W  = 3;
   localparam int NEST_W   = 8;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_WRITE = 2'd0,
      FUNC_BEGIN = 2'd1,
      FUNC_END   = 2'd2,
      FUNC_TICK  = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_ADDR   = 3'd1,
      PH_SHIFT  = 3'd2,
      PH_ALE_HI = 3'd3,
      PH_WE_HI  = 3'd4,
      PH_WE_LO  = 3'd5,
      PH_ALE_LO = 3'd6,
      PH_FINISH = 3'd7
   } scan_phase_type;

   typedef enum logic {
      CTL_IDLE = 1'b0,
      CTL_EXEC = 1'b1
   } ctl_state_type;

endpackage

/* sv/two_color_led_matrix_refresher_unit.sv */
// two-color led matrix refresher: plane memory, pin sequencer and item handshake
// the plane word is registered at acceptance; the update is made in the execute state and the result is then registered
// a new item is accepted only once the previous update is done, as the plane memory is read ahead of the update;
// a waiting result holds the next update until taken
// reset: synchronous, active high; clears 64 per-word valid bits so both planes
// read as zero at once, plus all sequencer, pin and handshake state
module two_color_led_matrix_refresher_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [tclmr_pkg::PANEL_W-1:0]   csr_write_data,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [tclmr_pkg::FUNC_W-1:0]    req_func,
   input  logic [tclmr_pkg::X_W-1:0]       req_x_pos,
   input  logic [tclmr_pkg::Y_W-1:0]       req_y_pos,
   input  logic [tclmr_pkg::COLOR_W-1:0]   req_color,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [tclmr_pkg::ROW_W-1:0]     rsp_row_addr,
   output logic                            rsp_red_data,
   output logic                            rsp_green_data,
   output logic                            rsp_shift_clock,
   output logic                            rsp_write_enable,
   output logic                            rsp_latch_enable,
   output logic                            rsp_busy_res
);

   localparam int WORD_BITS = 2 * tclmr_pkg::PANEL_COLUMNS;

   tclmr_pkg::ctl_state_type ctl_ff, ctl_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [tclmr_pkg::PANEL_W-1:0] panel_count_ff;

   // captured item
   tclmr_pkg::func_type func_ff;
   logic [tclmr_pkg::X_W-1:0] x_ff;
   logic [tclmr_pkg::Y_W-1:0] y_ff;
   logic [tclmr_pkg::COLOR_W-1:0] color_ff;
   logic [tclmr_pkg::ADDR_W-1:0] addr_ff;

   // plane memory, red in the low half and green in the high half
   logic [WORD_BITS-1:0] plane_mem [tclmr_pkg::WORD_COUNT];
   logic [WORD_BITS-1:0] rdata_ff;
   logic [tclmr_pkg::WORD_COUNT-1:0] valid_ff, valid_in;
   logic mem_we;
   logic [WORD_BITS-1:0] mem_wdata;
   logic [tclmr_pkg::ADDR_W-1:0] rd_addr;
   logic accept;

   // sequencer and pins
   logic [tclmr_pkg::NEST_W-1:0] nest_ff, nest_in;
   logic [tclmr_pkg::ROW_W-1:0] scan_row_ff, scan_row_in;
   logic [tclmr_pkg::WIDTH_W-1:0] scan_col_ff, scan_col_in;
   tclmr_pkg::scan_phase_type phase_ff, phase_in;
   logic [tclmr_pkg::ROW_W-1:0] row_addr_ff, row_addr_in;
   logic dr_ff, dr_in, dg_ff, dg_in, clk_ff, clk_in, we_ff, we_in, ale_ff, ale_in;

   logic done;
   logic [tclmr_pkg::PANEL_W-1:0] pc_sat;
   logic [tclmr_pkg::WIDTH_W-1:0] width;
   logic [tclmr_pkg::WIDTH_W-1:0] col_next;
   logic [tclmr_pkg::PANEL_COLUMNS-1:0] red_word, green_word, red_new, green_new;
   logic [tclmr_pkg::BIT_W-1:0] bit_sel;
   logic in_range;

   assign accept    = req_valid && (ctl_ff == tclmr_pkg::CTL_IDLE);
   assign req_stall = (ctl_ff != tclmr_pkg::CTL_IDLE);

   // word index is row * panels + column / 32
   always_comb begin
      if (tclmr_pkg::func_type'(req_func) == tclmr_pkg::FUNC_TICK) begin
         rd_addr = tclmr_pkg::ADDR_W'(int'(scan_row_ff) * tclmr_pkg::MAX_PANELS
                   + int'(scan_col_ff >> tclmr_pkg::BIT_W));
      end else begin
         rd_addr = tclmr_pkg::ADDR_W'(int'(req_y_pos) * tclmr_pkg::MAX_PANELS
                   + int'(req_x_pos >> tclmr_pkg::BIT_W));
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         plane_mem[addr_ff] <= mem_wdata;
      end
      if (accept) begin
         rdata_ff <= plane_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff  <= tclmr_pkg::func_type'(req_func);
         x_ff     <= req_x_pos;
         y_ff     <= req_y_pos;
         color_ff <= req_color;
         addr_ff  <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff         <= tclmr_pkg::CTL_IDLE;
         rsp_valid_ff   <= 1'b0;
         panel_count_ff <= tclmr_pkg::PANEL_W'(1);
         valid_ff       <= '0;
         nest_ff        <= '0;
         scan_row_ff    <= '0;
         scan_col_ff    <= '0;
         phase_ff       <= tclmr_pkg::PH_IDLE;
         row_addr_ff    <= '0;
         dr_ff          <= 1'b0;
         dg_ff          <= 1'b0;
         clk_ff         <= 1'b0;
         we_ff          <= 1'b0;
         ale_ff         <= 1'b0;
      end else begin
         ctl_ff       <= ctl_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            panel_count_ff <= csr_write_data;
         end
         valid_ff    <= valid_in;
         nest_ff     <= nest_in;
         scan_row_ff <= scan_row_in;
         scan_col_ff <= scan_col_in;
         phase_ff    <= phase_in;
         row_addr_ff <= row_addr_in;
         dr_ff       <= dr_in;
         dg_ff       <= dg_in;
         clk_ff      <= clk_in;
         we_ff       <= we_in;
         ale_ff      <= ale_in;
      end
   end

   always_comb begin
      pc_sat = (int'(panel_count_ff) > tclmr_pkg::MAX_PANELS)
               ? tclmr_pkg::PANEL_W'(tclmr_pkg::MAX_PANELS) : panel_count_ff;
      width  = tclmr_pkg::WIDTH_W'(pc_sat) * tclmr_pkg::WIDTH_W'(tclmr_pkg::PANEL_COLUMNS);
      col_next = scan_col_ff + tclmr_pkg::WIDTH_W'(1);

      // a word never written reads as zero
      red_word   = valid_ff[addr_ff] ? rdata_ff[tclmr_pkg::PANEL_COLUMNS-1:0] : '0;
      green_word = valid_ff[addr_ff] ? rdata_ff[WORD_BITS-1:tclmr_pkg::PANEL_COLUMNS] : '0;

      in_range = (x_ff < tclmr_pkg::X_W'(width))
                 && (int'(y_ff) < tclmr_pkg::PANEL_ROWS);
      bit_sel  = x_ff[tclmr_pkg::BIT_W-1:0];
      red_new  = red_word;
      green_new = green_word;
      red_new[bit_sel]   = color_ff[0];
      green_new[bit_sel] = color_ff[1];
      mem_wdata = {green_new, red_new};

      done = (ctl_ff == tclmr_pkg::CTL_EXEC) && (!rsp_valid_ff || !rsp_stall);

      ctl_in       = ctl_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mem_we       = 1'b0;
      valid_in     = valid_ff;
      nest_in      = nest_ff;
      scan_row_in  = scan_row_ff;
      scan_col_in  = scan_col_ff;
      phase_in     = phase_ff;
      row_addr_in  = row_addr_ff;
      dr_in        = dr_ff;
      dg_in        = dg_ff;
      clk_in       = clk_ff;
      we_in        = we_ff;
      ale_in       = ale_ff;

      unique case (ctl_ff)
         tclmr_pkg::CTL_IDLE: begin
            if (accept) begin
               ctl_in = tclmr_pkg::CTL_EXEC;
            end
         end
         tclmr_pkg::CTL_EXEC: begin
            if (done) begin
               ctl_in       = tclmr_pkg::CTL_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
      endcase

      if (done) begin
         unique case (func_ff)
            tclmr_pkg::FUNC_WRITE: begin
               if (in_range) begin
                  mem_we            = 1'b1;
                  valid_in[addr_ff] = 1'b1;
               end
            end
            tclmr_pkg::FUNC_BEGIN: begin
               if (nest_ff != '1) begin
                  nest_in = nest_ff + tclmr_pkg::NEST_W'(1);
               end
            end
            tclmr_pkg::FUNC_END: begin
               // closing the outermost level, or an unmatched end, restarts the scan
               if (nest_ff != '0) begin
                  nest_in = nest_ff - tclmr_pkg::NEST_W'(1);
               end
               if (nest_ff <= tclmr_pkg::NEST_W'(1)) begin
                  scan_row_in = '0;
                  scan_col_in = '0;
                  phase_in    = tclmr_pkg::PH_ADDR;
               end
            end
            tclmr_pkg::FUNC_TICK: begin
               unique case (phase_ff)
                  tclmr_pkg::PH_IDLE: begin
                  end
                  tclmr_pkg::PH_ADDR: begin
                     row_addr_in = scan_row_ff;
                     clk_in      = 1'b0;
                     we_in       = 1'b0;
                     ale_in      = 1'b0;
                     scan_col_in = '0;
                     phase_in    = (width == '0) ? tclmr_pkg::PH_ALE_HI : tclmr_pkg::PH_SHIFT;
                  end
                  tclmr_pkg::PH_SHIFT: begin
                     if (scan_col_ff >= width) begin
                        scan_col_in = '0;
                        phase_in    = tclmr_pkg::PH_ALE_HI;
                     end else if (!clk_ff) begin
                        dr_in  = red_word[scan_col_ff[tclmr_pkg::BIT_W-1:0]];
                        dg_in  = green_word[scan_col_ff[tclmr_pkg::BIT_W-1:0]];
                        clk_in = 1'b1;
                     end else begin
                        clk_in = 1'b0;
                        if (col_next >= width) begin
                           scan_col_in = '0;
                           phase_in    = tclmr_pkg::PH_ALE_HI;
                        end else begin
                           scan_col_in = col_next;
                        end
                     end
                  end
                  tclmr_pkg::PH_ALE_HI: begin
                     ale_in   = 1'b1;
                     phase_in = tclmr_pkg::PH_WE_HI;
                  end
                  tclmr_pkg::PH_WE_HI: begin
                     we_in    = 1'b1;
                     phase_in = tclmr_pkg::PH_WE_LO;
                  end
                  tclmr_pkg::PH_WE_LO: begin
                     we_in    = 1'b0;
                     phase_in = tclmr_pkg::PH_ALE_LO;
                  end
                  tclmr_pkg::PH_ALE_LO: begin
                     ale_in = 1'b0;
                     if (int'(scan_row_ff) >= tclmr_pkg::PANEL_ROWS - 1) begin
                        phase_in = tclmr_pkg::PH_FINISH;
                     end else begin
                        scan_row_in = scan_row_ff + tclmr_pkg::ROW_W'(1);
                        phase_in    = tclmr_pkg::PH_ADDR;
                     end
                  end
                  tclmr_pkg::PH_FINISH: begin
                     row_addr_in = '0;
                     scan_row_in = '0;
                     scan_col_in = '0;
                     phase_in    = tclmr_pkg::PH_IDLE;
                  end
               endcase
            end
         endcase
      end
   end

   // pin registers change only when the previous result has left
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_row_addr     = row_addr_ff;
   assign rsp_red_data     = dr_ff;
   assign rsp_green_data   = dg_ff;
   assign rsp_shift_clock  = clk_ff;
   assign rsp_write_enable = we_ff;
   assign rsp_latch_enable = ale_ff;
   assign rsp_busy_res     = (phase_ff != tclmr_pkg::PH_IDLE);

endmodule

/* sv/tclmr_checker.sv */
// port-level checks for the two-color led matrix refresher, bound to the top level
module tclmr_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [tclmr_pkg::ROW_W-1:0] rsp_row_addr,
   input logic                        rsp_red_data,
   input logic                        rsp_green_data,
   input logic                        rsp_shift_clock,
   input logic                        rsp_write_enable,
   input logic                        rsp_latch_enable,
   input logic                        rsp_busy_res
);

   // a waiting item keeps all its pin levels
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_row_addr)
         && $stable(rsp_red_data) && $stable(rsp_green_data)
         && $stable(rsp_shift_clock) && $stable(rsp_write_enable)
         && $stable(rsp_latch_enable) && $stable(rsp_busy_res))
      else $error("result changed while stalled");

   // an idle panel has both strobes low
   a_idle_strobes: assert property (@(posedge clock) disable iff (reset)
      !rsp_busy_res |-> !rsp_write_enable && !rsp_latch_enable)
      else $error("strobe high while idle");

   // write strobe only inside the latch window
   a_we_ale: assert property (@(posedge clock) disable iff (reset)
      rsp_write_enable |-> rsp_latch_enable)
      else $error("write strobe outside latch window");

   // an idle panel sits at row zero
   a_idle_row: assert property (@(posedge clock) disable iff (reset)
      !rsp_busy_res |-> (rsp_row_addr == '0))
      else $error("row address not zero while idle");

endmodule

bind two_color_led_matrix_refresher_unit tclmr_checker u_tclmr_checker (.*);
